// ===== design/ntc_thermistor_scan_convert_defines.svh =====
// Assertion macros shared by the ntcsc design files.
`ifndef NTC_THERMISTOR_SCAN_CONVERT_DEFINES_SVH
`define NTC_THERMISTOR_SCAN_CONVERT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define NTCSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntcsc check failed");
// next-cycle implication
`define NTCSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntcsc check failed");
`else
`define NTCSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NTCSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== design/ntcsc_pkg.sv =====
// Shared constants, codes and types of the thermistor scan converter.
package ntcsc_pkg;

    // configuration
    localparam int MUX_TOTAL     = 4;
    localparam int LINES_PER_MUX = 8;
    localparam int ADC_BITS      = 12;

    // port field widths
    localparam int MUX_W      = 2;
    localparam int SEL_W      = 3;
    localparam int ADC_W      = 12;
    localparam int IDX_W      = 5;
    localparam int TEMP_W     = 8;
    localparam int SPM_W      = 4;
    localparam int UNPOP_W    = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam int MUX_SLOTS  = 4;   // mux slots covered by the unpopulated-line register

    localparam int TBL_DEPTH = 2 ** ADC_BITS;
    localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNPOP = 1'b0,
        CFG_SPM   = 1'b1
    } t_cfg_reg;

    localparam logic [SPM_W-1:0] SPM_RESET = 4'd6;

    // converter constants
    localparam int V_W = 26;                              // divider products p, q
    localparam logic [V_W-1:0] R_NOMINAL = 26'd10000;
    localparam logic [V_W-1:0] R_ADJUST  = 26'd850;
    localparam logic [29:0]    LN2_Q30   = 30'd744261118;
    localparam logic [14:0]    K_BETA_T0 = 15'd29815;     // 298.15 K scaled by 100
    localparam logic [14:0]    K_ZERO_C  = 15'd27315;     // 273.15 K scaled by 100
    localparam logic [63:0]    D_BASE    = 64'd393000 << 28;
    localparam logic [63:0]    NUM_BASE  = (64'd100 * 64'd3930 * 64'd29815) << 28;

    localparam logic signed [TEMP_W-1:0] TEMP_SHORT = -8'sd60;
    localparam logic signed [TEMP_W-1:0] TEMP_OPEN  = 8'sh80;

    // divider steps per request
    localparam int DIV_STEP_W = 6;
    localparam int DIV_Q_W    = 32;
    localparam logic [DIV_STEP_W-1:0] Z_STEPS   = 6'd29;
    localparam logic [DIV_STEP_W-1:0] QUO_STEPS = 6'd8;

    typedef struct packed {
        logic                  short_flag;
        logic signed [TEMP_W-1:0] temp;
    } t_tbl_ent;

    typedef struct packed {
        logic                en;
        logic [ADC_BITS-1:0] addr;
        t_tbl_ent            data;
    } t_tbl_wr;

    typedef struct packed {
        logic                  start;
        logic [63:0]           dividend;
        logic [63:0]           divisor;   // already aligned to the top quotient bit
        logic [DIV_STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_Q_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [4:0] {
        FILL_SETUP,
        FILL_NORM,
        FILL_ZREQ,
        FILL_ZWAIT,
        FILL_ZSQ,
        FILL_TCHK,
        FILL_TREQ,
        FILL_TWAIT,
        FILL_TMUL,
        FILL_LNEND,
        FILL_D0,
        FILL_MULD,
        FILL_D1,
        FILL_MULN,
        FILL_N1,
        FILL_N2,
        FILL_N3,
        FILL_N4,
        FILL_QWAIT,
        FILL_WR,
        FILL_DONE
    } t_fill_st;

endpackage

// ===== design/ntcsc_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ntcsc_div import ntcsc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_cnt;
    logic [63:0]           r_rem;
    logic [63:0]           r_dvs;
    logic [DIV_Q_W-1:0]    r_quo;
    logic                  w_ge;

    assign w_ge = (r_rem >= r_dvs);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (r_rem - r_dvs) : r_rem;
            r_dvs <= r_dvs >> 1;
            r_quo <= {r_quo[DIV_Q_W-2:0], w_ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== design/ntcsc_lut.sv =====
// Temperature table: one write port, one registered read port.
module ntcsc_lut import ntcsc_pkg::*; (
    input  logic                i_clk,
    input  t_tbl_wr             i_wr,
    input  logic                i_rd_en,
    input  logic [ADC_BITS-1:0] i_rd_addr,
    output t_tbl_ent            o_rd_data
);

    t_tbl_ent mem [TBL_DEPTH];
    t_tbl_ent r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/ntcsc_fill.sv =====
// Table builder: fills every code's entry after reset, most by the beta equation.
module ntcsc_fill import ntcsc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_rsp i_div_rsp,
    output t_div_req o_div_req,
    output t_tbl_wr  o_wr,
    output logic     o_busy
);

`include "ntc_thermistor_scan_convert_defines.svh"

    t_fill_st r_st;
    t_fill_st n_st;

    logic [ADC_BITS-1:0] r_code;
    logic [V_W-1:0]      r_qop;     // second log operand, waits while the first runs
    logic                r_which;
    logic [30:0]         r_m;       // normalized mantissa, Q30
    logic [4:0]          r_s;       // normalizing shift count
    logic [28:0]         r_z;
    logic [27:0]         r_z2;
    logic [28:0]         r_term;
    logic [29:0]         r_sum;
    logic [6:0]          r_i;
    logic [33:0]         r_lnp;
    logic [33:0]         r_lnq;
    logic [63:0]         r_acc;
    logic [63:0]         r_mx;
    logic [14:0]         r_mk;
    logic [63:0]         r_d;
    logic [63:0]         r_num;
    logic                r_neg;
    logic [63:0]         r_mag;
    logic [63:0]         r_hd;      // 100 * d
    logic [63:0]         r_dvd;
    logic [63:0]         r_dvs;     // 200 * d
    logic                r_wshort;
    logic [TEMP_W-1:0]   r_wtemp;

    logic [19:0]        w_c101;
    logic               w_short;
    logic [V_W-1:0]     w_p;
    logic [V_W-1:0]     w_q;
    logic [57:0]        w_zz;
    logic [56:0]        w_tz;
    logic [4:0]         w_k;
    logic [35:0]        w_ln30;
    logic [33:0]        w_ln28;
    logic signed [34:0] w_l;
    logic [63:0]        w_d;
    logic               w_d_bad;
    logic               w_clamp;

    function automatic logic [TEMP_W-1:0] sat_temp(input logic neg, input logic [7:0] quo);
        logic [TEMP_W-1:0] res;
        if (!neg) begin
            res = (quo > 8'd127) ? 8'd127 : quo;
        end else begin
            res = (quo > 8'd128) ? TEMP_OPEN : 8'(~quo + 8'd1);
        end
        return res;
    endfunction

    // short when 10000*c < 100*(F-c), i.e. 101*c < F
    assign w_c101  = 20'(r_code) * 20'd101;
    assign w_short = (w_c101 < 20'(FULL_SCALE));
    assign w_p     = V_W'(r_code) * R_NOMINAL + V_W'(FULL_SCALE - r_code) * R_ADJUST;
    assign w_q     = V_W'(FULL_SCALE - r_code) * R_NOMINAL;

    assign w_zz    = r_z * r_z;
    assign w_tz    = r_term * r_z2;
    assign w_k     = 5'd30 - r_s;
    assign w_ln30  = 36'({r_sum, 1'b0}) + 36'(w_k) * 36'(LN2_Q30);
    assign w_ln28  = 34'((w_ln30 + 36'd2) >> 2);
    assign w_l     = $signed({1'b0, r_lnp}) - $signed({1'b0, r_lnq});
    assign w_d     = r_acc + D_BASE;
    assign w_d_bad = w_d[63] || (w_d == '0);
    assign w_clamp = (r_dvd >= (r_dvs << QUO_STEPS));

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            FILL_SETUP: begin
                if (w_short || (r_code == FULL_SCALE)) begin
                    n_st = FILL_WR;
                end else begin
                    n_st = FILL_NORM;
                end
            end
            FILL_NORM:  n_st = r_m[30] ? FILL_ZREQ : FILL_NORM;
            FILL_ZREQ:  n_st = FILL_ZWAIT;
            FILL_ZWAIT: n_st = i_div_rsp.done ? FILL_ZSQ : FILL_ZWAIT;
            FILL_ZSQ:   n_st = FILL_TCHK;
            FILL_TCHK: begin
                if ((r_term == '0) || (r_i == 7'd64)) begin
                    n_st = FILL_LNEND;
                end else begin
                    n_st = FILL_TREQ;
                end
            end
            FILL_TREQ:  n_st = FILL_TWAIT;
            FILL_TWAIT: n_st = i_div_rsp.done ? FILL_TMUL : FILL_TWAIT;
            FILL_TMUL:  n_st = FILL_TCHK;
            FILL_LNEND: n_st = r_which ? FILL_D0 : FILL_NORM;
            FILL_D0:    n_st = FILL_MULD;
            FILL_MULD:  n_st = (r_mk == '0) ? FILL_D1 : FILL_MULD;
            FILL_D1:    n_st = w_d_bad ? FILL_WR : FILL_MULN;
            FILL_MULN:  n_st = (r_mk == '0) ? FILL_N1 : FILL_MULN;
            FILL_N1:    n_st = FILL_N2;
            FILL_N2:    n_st = FILL_N3;
            FILL_N3:    n_st = FILL_N4;
            FILL_N4:    n_st = w_clamp ? FILL_WR : FILL_QWAIT;
            FILL_QWAIT: n_st = i_div_rsp.done ? FILL_WR : FILL_QWAIT;
            FILL_WR:    n_st = (r_code == FULL_SCALE) ? FILL_DONE : FILL_SETUP;
            FILL_DONE:  n_st = FILL_DONE;
            default:    n_st = FILL_DONE;
        endcase
    end

    // outputs
    always_comb begin
        o_div_req         = '0;
        o_busy            = (r_st != FILL_DONE);
        o_wr.en           = (r_st == FILL_WR);
        o_wr.addr         = r_code;
        o_wr.data.short_flag = r_wshort;
        o_wr.data.temp    = r_wtemp;
        unique case (r_st)
            FILL_ZREQ: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = 64'(r_m[29:0]) << 30;
                o_div_req.divisor  = (64'(r_m) + (64'd1 << 30)) << (Z_STEPS - 1'b1);
                o_div_req.steps    = Z_STEPS;
            end
            FILL_TREQ: begin
                o_div_req.start    = 1'b1;
                o_div_req.dividend = 64'(r_term);
                o_div_req.divisor  = 64'({r_i, 1'b1}) << (Z_STEPS - 1'b1);
                o_div_req.steps    = Z_STEPS;
            end
            FILL_N4: begin
                o_div_req.start    = !w_clamp;
                o_div_req.dividend = r_dvd;
                o_div_req.divisor  = r_dvs << (QUO_STEPS - 1'b1);
                o_div_req.steps    = QUO_STEPS;
            end
            default: begin
                o_div_req = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= FILL_SETUP;
            r_code <= '0;
        end else begin
            r_st <= n_st;
            if ((r_st == FILL_WR) && (r_code != FULL_SCALE)) begin
                r_code <= r_code + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            FILL_SETUP: begin
                r_wshort <= w_short;
                r_wtemp  <= w_short ? TEMP_SHORT : TEMP_OPEN;
                r_m      <= 31'(w_p);
                r_s      <= '0;
                r_qop    <= w_q;
                r_which  <= 1'b0;
            end
            FILL_NORM: begin
                if (!r_m[30]) begin
                    r_m <= r_m << 1;
                    r_s <= r_s + 1'b1;
                end
            end
            FILL_ZWAIT: begin
                r_z <= i_div_rsp.quo[28:0];
            end
            FILL_ZSQ: begin
                r_z2   <= w_zz[57:30];
                r_term <= r_z;
                r_i    <= '0;
                r_sum  <= '0;
            end
            FILL_TWAIT: begin
                if (i_div_rsp.done) begin
                    r_sum <= r_sum + 30'(i_div_rsp.quo[28:0]);
                end
            end
            FILL_TMUL: begin
                r_term <= 29'(w_tz >> 30);
                r_i    <= r_i + 1'b1;
            end
            FILL_LNEND: begin
                if (!r_which) begin
                    r_lnp   <= w_ln28;
                    r_m     <= 31'(r_qop);
                    r_s     <= '0;
                    r_which <= 1'b1;
                end else begin
                    r_lnq <= w_ln28;
                end
            end
            FILL_D0: begin
                r_acc <= '0;
                r_mx  <= {{29{w_l[34]}}, w_l};
                r_mk  <= K_BETA_T0;
            end
            FILL_MULD, FILL_MULN: begin
                if (r_mk != '0) begin
                    r_acc <= r_acc + (r_mk[0] ? r_mx : 64'd0);
                    r_mx  <= r_mx << 1;
                    r_mk  <= r_mk >> 1;
                end
            end
            FILL_D1: begin
                r_d     <= w_d;
                r_wtemp <= TEMP_OPEN;
                r_acc   <= '0;
                r_mx    <= w_d;
                r_mk    <= K_ZERO_C;
            end
            FILL_N1: begin
                r_num <= NUM_BASE - r_acc;
            end
            FILL_N2: begin
                r_neg <= r_num[63];
                r_mag <= r_num[63] ? (~r_num + 64'd1) : r_num;
                r_hd  <= (r_d << 6) + (r_d << 5) + (r_d << 2);
            end
            FILL_N3: begin
                r_dvd <= (r_mag << 1) + r_hd;
                r_dvs <= r_hd << 1;
            end
            FILL_N4: begin
                if (w_clamp) begin
                    r_wtemp <= sat_temp(r_neg, 8'd200);
                end
            end
            FILL_QWAIT: begin
                if (i_div_rsp.done) begin
                    r_wtemp <= sat_temp(r_neg, i_div_rsp.quo[7:0]);
                end
            end
            default: begin
            end
        endcase
    end

    `NTCSC_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, o_div_req.start, !i_div_rsp.busy)
    `NTCSC_ASSERT_NXT(a_code_step, i_clk, i_rst_n, (r_st == FILL_WR) && (r_code != FULL_SCALE), r_code == $past(r_code) + 1'b1)
    `NTCSC_ASSERT_NXT(a_done_hold, i_clk, i_rst_n, r_st == FILL_DONE, (r_st == FILL_DONE) && !o_wr.en)

endmodule

// ===== design/ntc_thermistor_scan_convert.sv =====
// Top level: thermistor ADC readings in, packed index and temperature out.
//
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_stall         i_mux_number, i_select_line, i_adc_code
//  result    out        o_valid / i_stall         o_sensor_index, o_temperature_c, o_short_flag
//  config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One reading per cycle while o_stall is low; a result passes through the table
// read, then the output register. Readings on unpopulated lines give no result.
// After reset the table builder fills the entry of every ADC code, converting
// most of them with a shared bit-serial divider, with o_stall high until it is
// done. Config writes are taken at any time; a result stall backs up through
// one stage into o_stall.
module ntc_thermistor_scan_convert import ntcsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input readings
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [MUX_W-1:0]      i_mux_number,
    input  logic [SEL_W-1:0]      i_select_line,
    input  logic [ADC_W-1:0]      i_adc_code,
    // results
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [IDX_W-1:0]      o_sensor_index,
    output logic signed [TEMP_W-1:0] o_temperature_c,
    output logic                  o_short_flag,
    // configuration writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

`include "ntc_thermistor_scan_convert_defines.svh"

    // configuration registers
    logic [UNPOP_W-1:0] r_unpop;
    logic [SPM_W-1:0]   r_spm;

    // table builder and table
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    t_tbl_wr  w_tbl_wr;
    t_tbl_ent w_rd_data;
    logic     w_fill_busy;

    // item path
    logic [SEL_W-1:0]    w_first [MUX_SLOTS];
    logic [SEL_W-1:0]    w_second [MUX_SLOTS];
    logic [SEL_W-1:0]    w_lo;
    logic [SEL_W-1:0]    w_hi;
    logic                w_in_range;
    logic                w_keep;
    logic [6:0]          w_idx_full;
    logic [ADC_BITS-1:0] w_code;
    logic                w_accept;
    logic                w_blocked;
    logic                w_a_move;

    logic             r_a_vld;     // table read in flight
    logic [IDX_W-1:0] r_a_idx;
    logic             r_o_vld;
    logic [IDX_W-1:0] r_o_idx;
    t_tbl_ent         r_o_ent;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unpop <= '0;
            r_spm   <= SPM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_UNPOP: r_unpop <= i_cfg_data[UNPOP_W-1:0];
                CFG_SPM:   r_spm   <= i_cfg_data[SPM_W-1:0];
                default:   r_spm   <= r_spm;
            endcase
        end
    end

    ntcsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    ntcsc_fill u_fill (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_div_rsp (w_div_rsp),
        .o_div_req (w_div_req),
        .o_wr      (w_tbl_wr),
        .o_busy    (w_fill_busy)
    );

    ntcsc_lut u_lut (
        .i_clk     (i_clk),
        .i_wr      (w_tbl_wr),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_code),
        .o_rd_data (w_rd_data)
    );

    // per-mux unpopulated line pair: first line in the low three bits
    always_comb begin
        for (int m = 0; m < MUX_SLOTS; m++) begin
            w_first[m]  = r_unpop[2*SEL_W*m +: SEL_W];
            w_second[m] = r_unpop[2*SEL_W*m + SEL_W +: SEL_W];
        end
    end

    assign w_lo = w_first[i_mux_number];
    assign w_hi = w_second[i_mux_number];

    assign w_in_range = (32'(i_mux_number) < MUX_TOTAL) &&
                        (32'(i_select_line) < LINES_PER_MUX);
    assign w_keep     = w_in_range && (i_select_line != w_lo) && (i_select_line != w_hi);

    // packed index, wraps modulo 32 for odd configurations
    assign w_idx_full = 7'(i_mux_number) * 7'(r_spm) + 7'(i_select_line)
                      - 7'(i_select_line >= w_lo) - 7'(i_select_line >= w_hi);

    // codes above full scale read the full-scale entry
    assign w_code = (i_adc_code > ADC_W'(FULL_SCALE)) ? FULL_SCALE
                                                       : i_adc_code[ADC_BITS-1:0];

    // stage A holds while the output register is full and stalled; the table
    // keeps its read data because no new read is issued meanwhile
    assign w_blocked = r_o_vld && i_stall;
    assign w_a_move  = r_a_vld && !w_blocked;
    assign o_stall   = w_fill_busy || (r_a_vld && w_blocked);
    assign w_accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (w_accept) begin
                r_a_vld <= w_keep;
            end else if (w_a_move) begin
                r_a_vld <= 1'b0;
            end
            if (w_a_move) begin
                r_o_vld <= 1'b1;
            end else if (!i_stall) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_idx <= w_idx_full[IDX_W-1:0];
        end
        if (w_a_move) begin
            r_o_idx <= r_a_idx;
            r_o_ent <= w_rd_data;
        end
    end

    assign o_valid         = r_o_vld;
    assign o_sensor_index  = r_o_idx;
    assign o_temperature_c = r_o_ent.temp;
    assign o_short_flag    = r_o_ent.short_flag;

    `NTCSC_ASSERT_IMP(a_idle_in_fill, i_clk, i_rst_n, w_fill_busy, !r_a_vld && !r_o_vld)
    `NTCSC_ASSERT_NXT(a_stage_hold, i_clk, i_rst_n, r_a_vld && w_blocked, r_a_vld && $stable(r_a_idx))
    `NTCSC_ASSERT_NXT(a_rd_hold, i_clk, i_rst_n, r_a_vld && w_blocked, $stable(w_rd_data))
    `NTCSC_ASSERT_NXT(a_idx_flow, i_clk, i_rst_n, w_a_move, r_o_vld && (o_sensor_index == $past(r_a_idx)))

endmodule
